### design/barometer_compensation_core_macros.svh
// ----------------------------------------------------------------------------
// Barometer compensation core assertion macros
// Shared assertion forms for the checker of the compensation core.
// ----------------------------------------------------------------------------
`ifndef BAROMETER_COMPENSATION_CORE_MACROS_SVH
`define BAROMETER_COMPENSATION_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BCC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define BCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/bcc_pkg.sv
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared types and constants of the compensation pipeline.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int RawW      = 20;
    localparam int TempW     = 16;
    localparam int PressW    = 32;
    localparam int VarW      = 27;
    localparam int WordW     = 64;
    localparam int DenW      = 31;
    localparam int DivStages = WordW;

    localparam logic signed [VarW-1:0] TFineOffset = 27'sd128000;
    localparam logic [WordW-1:0]       BiasP1      = 64'h0000_8000_0000_0000;
    localparam logic [WordW-1:0]       NumScale    = 64'd3125;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_TEMP_CALIB = 2'd0,
        REG_PRESS_LO   = 2'd1,
        REG_PRESS_HI   = 2'd2,
        REG_PRESS_LAST = 2'd3
    } reg_idx_t;

    // Unpacked view of the factory calibration words.
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } calib_t;

    // Status that rides along with each word through the pipeline.
    typedef struct packed {
        logic             valid;
        logic             invalid;
        logic             neg;
        logic [TempW-1:0] temp;
    } tag_t;

endpackage

### design/barometer_compensation_core.sv
// ----------------------------------------------------------------------------
// Barometer compensation core
// Takes one raw temperature and pressure pair per word and returns the
// compensated temperature in 0.01 degC and pressure in Pa as unsigned Q24.8.
// The core accepts a new word every clock cycle while the output is not
// stalled; its latency is set mostly by the 64-stage divider that forms the
// pressure quotient, one bit per stage. A stall on the result side holds the
// whole pipeline, so s_tready follows m_tready whenever a result is waiting.
// Calibration registers are written through the plain write port; the user
// must write them only while the core is idle, the core does not enforce it.
// ----------------------------------------------------------------------------
module barometer_compensation_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Calibration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wr_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temp [19:0], raw_press [39:20]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // temp_centi [15:0], press_q24_8 [47:16]
    output logic        m_tuser    // press_invalid [0]
);
    import bcc_pkg::*;

    logic [47:0] temp_calib_reg;
    logic [63:0] press_lo_reg;
    logic [63:0] press_hi_reg;
    logic [15:0] press_last_reg;
    calib_t      calib;
    logic        en;

    tag_t                   tag_t2p, tag_p2d, tag_d2o, tag_out;
    logic signed [VarW-1:0] var1;
    logic [RawW-1:0]        press_adc;
    logic [WordW-1:0]       mag_num, quot;
    logic [DenW-1:0]        mag_den;
    logic [PressW-1:0]      press;

    // Calibration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_calib_reg <= '0;
            press_lo_reg   <= '0;
            press_hi_reg   <= '0;
            press_last_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_TEMP_CALIB: temp_calib_reg <= cfg_wr_data[47:0];
                REG_PRESS_LO:   press_lo_reg   <= cfg_wr_data;
                REG_PRESS_HI:   press_hi_reg   <= cfg_wr_data;
                REG_PRESS_LAST: press_last_reg <= cfg_wr_data[15:0];
            endcase
        end
    end

    // Unpack the calibration words.
    always_comb begin
        calib.t1 = temp_calib_reg[15:0];
        calib.t2 = temp_calib_reg[31:16];
        calib.t3 = temp_calib_reg[47:32];
        calib.p1 = press_lo_reg[15:0];
        calib.p2 = press_lo_reg[31:16];
        calib.p3 = press_lo_reg[47:32];
        calib.p4 = press_lo_reg[63:48];
        calib.p5 = press_hi_reg[15:0];
        calib.p6 = press_hi_reg[31:16];
        calib.p7 = press_hi_reg[47:32];
        calib.p8 = press_hi_reg[63:48];
        calib.p9 = press_last_reg;
    end

    // The pipeline advances whenever the output register is free or drains.
    assign en       = !tag_out.valid || m_tready;
    assign s_tready = en;

    bcc_temp u_temp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .raw_temp  (s_tdata[19:0]),
        .raw_press (s_tdata[39:20]),
        .calib     (calib),
        .tag_out   (tag_t2p),
        .var1      (var1),
        .press_adc (press_adc)
    );

    bcc_prediv u_prediv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .tag_in    (tag_t2p),
        .var1      (var1),
        .press_adc (press_adc),
        .calib     (calib),
        .tag_out   (tag_p2d),
        .mag_num   (mag_num),
        .mag_den   (mag_den)
    );

    bcc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .tag_in  (tag_p2d),
        .mag_num (mag_num),
        .mag_den (mag_den),
        .tag_out (tag_d2o),
        .quot    (quot)
    );

    bcc_post u_post (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .tag_in  (tag_d2o),
        .quot    (quot),
        .calib   (calib),
        .tag_out (tag_out),
        .press   (press)
    );

    assign m_tvalid = tag_out.valid;
    assign m_tdata  = {press, tag_out.temp};
    assign m_tuser  = tag_out.invalid;

endmodule

### design/bcc_temp.sv
// ----------------------------------------------------------------------------
// Temperature stages
// Forms the fine temperature and the clamped temperature in 0.01 degC.
// ----------------------------------------------------------------------------
module bcc_temp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [bcc_pkg::RawW-1:0]          raw_temp,
    input  logic [bcc_pkg::RawW-1:0]          raw_press,
    input  bcc_pkg::calib_t                   calib,
    output bcc_pkg::tag_t                     tag_out,
    output logic signed [bcc_pkg::VarW-1:0]   var1,
    output logic [bcc_pkg::RawW-1:0]          press_adc
);
    import bcc_pkg::*;

    logic [3:0]               vld_reg;
    logic signed [33:0]       pa_reg, pa_next;
    logic signed [33:0]       dd_reg, dd_next;
    logic signed [22:0]       a_reg, a_next;
    logic signed [37:0]       pb_reg, pb_next;
    logic signed [25:0]       tf_reg, tf_next;
    logic [TempW-1:0]         tc_reg, tc_next;
    logic signed [VarW-1:0]   v1_reg, v1_next;
    logic [RawW-1:0]          pr1_reg, pr2_reg, pr3_reg, pr4_reg;
    logic signed [17:0]       d1;
    logic signed [16:0]       d2;
    logic signed [29:0]       sc;
    logic signed [29:0]       tq;

    // Stage one: the two temperature products.
    always_comb begin
        d1      = $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, calib.t1, 1'b0});
        d2      = $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, calib.t1});
        pa_next = d1 * calib.t2;
        dd_next = d2 * d2;
    end

    // Stage two: scale and the third-coefficient product.
    always_comb begin
        a_next  = 23'(pa_reg >>> 11);
        pb_next = $signed({1'b0, dd_reg[32:12]}) * calib.t3;
    end

    // Stage three: fine temperature.
    assign tf_next = 26'(a_reg) + 26'(pb_reg >>> 14);

    // Stage four: output temperature with saturation, and the pressure offset.
    always_comb begin
        sc = (30'(tf_reg) <<< 2) + 30'(tf_reg) + 30'sd128;
        tq = sc >>> 8;
        if (tq > 30'sd32767) begin
            tc_next = 16'h7fff;
        end else if (tq < -30'sd32768) begin
            tc_next = 16'h8000;
        end else begin
            tc_next = tq[15:0];
        end
        v1_next = 27'(tf_reg) - TFineOffset;
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // Data registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg  <= pa_next;
            dd_reg  <= dd_next;
            pr1_reg <= raw_press;
            a_reg   <= a_next;
            pb_reg  <= pb_next;
            pr2_reg <= pr1_reg;
            tf_reg  <= tf_next;
            pr3_reg <= pr2_reg;
            tc_reg  <= tc_next;
            v1_reg  <= v1_next;
            pr4_reg <= pr3_reg;
        end
    end

    assign tag_out.valid   = vld_reg[3];
    assign tag_out.invalid = 1'b0;
    assign tag_out.neg     = 1'b0;
    assign tag_out.temp    = tc_reg;
    assign var1            = v1_reg;
    assign press_adc       = pr4_reg;

endmodule

### design/bcc_prediv.sv
// ----------------------------------------------------------------------------
// Pressure stages ahead of the divider
// Builds the dividend and divisor and splits them into sign and magnitude.
// ----------------------------------------------------------------------------
module bcc_prediv (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  bcc_pkg::tag_t                     tag_in,
    input  logic signed [bcc_pkg::VarW-1:0]   var1,
    input  logic [bcc_pkg::RawW-1:0]          press_adc,
    input  bcc_pkg::calib_t                   calib,
    output bcc_pkg::tag_t                     tag_out,
    output logic [bcc_pkg::WordW-1:0]         mag_num,
    output logic [bcc_pkg::DenW-1:0]          mag_den
);
    import bcc_pkg::*;

    tag_t                  tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg, tag6_reg;
    tag_t                  tag6_next;
    logic [RawW-1:0]       pr1_reg, pr2_reg, pr3_reg;
    logic signed [53:0]    vsq_reg, vsq_next;
    logic signed [42:0]    vp5_reg, vp5_next, vp5b_reg;
    logic signed [42:0]    vp2_reg, vp2_next, vp2b_reg;
    logic [WordW-1:0]      x6_reg, x6_next, x3_reg, x3_next;
    logic [WordW-1:0]      v2_reg, v2_next, va_reg, va_next;
    logic [WordW-1:0]      prod_reg, prod_next, num0_reg, num0_next;
    logic [WordW-1:0]      num_reg, num_next;
    logic signed [DenW-1:0] den_reg;
    logic [WordW-1:0]      mn_reg, mn_next;
    logic [DenW-1:0]       md_reg, md_next;
    logic signed [69:0]    m6, m3;
    logic signed [80:0]    m1;
    logic [RawW:0]         pt;

    // Stage one: square and linear terms of the temperature offset.
    always_comb begin
        vsq_next = var1 * var1;
        vp5_next = var1 * calib.p5;
        vp2_next = var1 * calib.p2;
    end

    // Stage two: products of the square term, kept modulo 2^64.
    always_comb begin
        m6      = vsq_reg * calib.p6;
        m3      = vsq_reg * calib.p3;
        x6_next = m6[63:0];
        x3_next = m3[63:0];
    end

    // Stage three: sums of the two partial expressions.
    always_comb begin
        v2_next = x6_reg + (64'(vp5b_reg) << 17) + (64'(calib.p4) << 35);
        va_next = 64'($signed(x3_reg) >>> 8) + (64'(vp2b_reg) << 12);
    end

    // Stage four: divisor product and the raw pressure term.
    always_comb begin
        m1        = $signed(va_reg + BiasP1) * $signed({1'b0, calib.p1});
        prod_next = m1[63:0];
        pt        = 21'h10_0000 - {1'b0, pr3_reg};
        num0_next = ({43'd0, pt} << 31) - v2_reg;
    end

    // Stage five: scale the dividend.
    assign num_next = num0_reg * NumScale;

    // Stage six: sign and magnitude split, zero divisor detection.
    always_comb begin
        tag6_next         = tag5_reg;
        tag6_next.neg     = num_reg[WordW-1] ^ den_reg[DenW-1];
        tag6_next.invalid = (den_reg == '0);
        mn_next           = num_reg[WordW-1] ? (64'd0 - num_reg) : num_reg;
        md_next           = den_reg[DenW-1] ? DenW'(-den_reg) : DenW'(den_reg);
    end

    // Valid bits ride in the tags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
            tag6_reg <= '0;
        end else if (en) begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
            tag6_reg <= tag6_next;
        end
    end

    // Data registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            vsq_reg  <= vsq_next;
            vp5_reg  <= vp5_next;
            vp2_reg  <= vp2_next;
            pr1_reg  <= press_adc;
            x6_reg   <= x6_next;
            x3_reg   <= x3_next;
            vp5b_reg <= vp5_reg;
            vp2b_reg <= vp2_reg;
            pr2_reg  <= pr1_reg;
            v2_reg   <= v2_next;
            va_reg   <= va_next;
            pr3_reg  <= pr2_reg;
            prod_reg <= prod_next;
            num0_reg <= num0_next;
            den_reg  <= $signed(prod_reg[63:33]);
            num_reg  <= num_next;
            mn_reg   <= mn_next;
            md_reg   <= md_next;
        end
    end

    assign tag_out = tag6_reg;
    assign mag_num = mn_reg;
    assign mag_den = md_reg;

endmodule

### design/bcc_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division of the dividend magnitude, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bcc_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  bcc_pkg::tag_t                tag_in,
    input  logic [bcc_pkg::WordW-1:0]    mag_num,
    input  logic [bcc_pkg::DenW-1:0]     mag_den,
    output bcc_pkg::tag_t                tag_out,
    output logic [bcc_pkg::WordW-1:0]    quot
);
    import bcc_pkg::*;

    logic [DenW-1:0]  rem_reg [DivStages];
    logic [WordW-1:0] dq_reg  [DivStages];
    logic [DenW-1:0]  den_reg [DivStages];
    tag_t             tag_reg [DivStages];

    for (genvar k = 0; k < DivStages; k++) begin : g_stage
        logic [DenW-1:0]  rem_in;
        logic [WordW-1:0] dq_in;
        logic [DenW-1:0]  den_in;
        tag_t             tag_k;
        logic [DenW:0]    trial;
        logic [DenW:0]    diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign dq_in  = mag_num;
            assign den_in = mag_den;
            assign tag_k  = tag_in;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign dq_in  = dq_reg[k-1];
            assign den_in = den_reg[k-1];
            assign tag_k  = tag_reg[k-1];
        end

        // Shift in the next dividend bit and try a subtraction.
        always_comb begin
            trial = {rem_in, dq_in[WordW-1]};
            diff  = trial - {1'b0, den_in};
            ge    = (trial >= {1'b0, den_in});
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[k] <= '0;
            end else if (en) begin
                tag_reg[k] <= tag_k;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
                dq_reg[k]  <= {dq_in[WordW-2:0], ge};
                den_reg[k] <= den_in;
            end
        end
    end

    assign tag_out = tag_reg[DivStages-1];
    assign quot    = dq_reg[DivStages-1];

endmodule

### design/bcc_post.sv
// ----------------------------------------------------------------------------
// Pressure stages after the divider
// Applies the sign and the second-order correction and drives the output.
// ----------------------------------------------------------------------------
module bcc_post (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  bcc_pkg::tag_t                 tag_in,
    input  logic [bcc_pkg::WordW-1:0]     quot,
    input  bcc_pkg::calib_t               calib,
    output bcc_pkg::tag_t                 tag_out,
    output logic [bcc_pkg::PressW-1:0]    press
);
    import bcc_pkg::*;

    tag_t               tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg, tag6_reg;
    logic [WordW-1:0]   p1_reg, p1_next, p2_reg, p3_reg, p4_reg, s_reg, s_next;
    logic [WordW-1:0]   ps_reg, a9_reg, b8_reg, b8b_reg, b8c_reg;
    logic [WordW-1:0]   ll_reg, ll_next, prod_reg, prod_next;
    logic [31:0]        lh_reg, lh_next, hl_reg, hl_next;
    logic [PressW-1:0]  press_reg, press_next;
    logic signed [WordW-1:0] ps;
    logic signed [79:0] a9m, b8m;

    // Stage one: restore the quotient sign.
    assign p1_next = tag_in.neg ? (64'd0 - quot) : quot;

    // Stage two: products with the eighth and ninth coefficients.
    always_comb begin
        ps  = $signed(p1_reg) >>> 13;
        a9m = calib.p9 * ps;
        b8m = calib.p8 * $signed(p1_reg);
    end

    // Stage three: 32-bit partial products of the square term.
    always_comb begin
        ll_next = a9_reg[31:0] * ps_reg[31:0];
        lh_next = a9_reg[31:0] * ps_reg[63:32];
        hl_next = a9_reg[63:32] * ps_reg[31:0];
    end

    // Stage four: combine partial products modulo 2^64.
    assign prod_next = ll_reg + {lh_reg + hl_reg, 32'd0};

    // Stage five: correction sum.
    assign s_next = p4_reg + 64'($signed(prod_reg) >>> 25) + 64'($signed(b8c_reg) >>> 19);

    // Stage six: final scaling and offset, zero for a zero divisor.
    always_comb begin
        if (tag5_reg.invalid) begin
            press_next = '0;
        end else begin
            press_next = s_reg[39:8] + (32'(calib.p7) << 4);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
            tag6_reg <= '0;
        end else if (en) begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
            tag6_reg <= tag5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg    <= p1_next;
            p2_reg    <= p1_reg;
            ps_reg    <= ps;
            a9_reg    <= a9m[63:0];
            b8_reg    <= b8m[63:0];
            p3_reg    <= p2_reg;
            ll_reg    <= ll_next;
            lh_reg    <= lh_next;
            hl_reg    <= hl_next;
            b8b_reg   <= b8_reg;
            p4_reg    <= p3_reg;
            prod_reg  <= prod_next;
            b8c_reg   <= b8b_reg;
            s_reg     <= s_next;
            press_reg <= press_next;
        end
    end

    assign tag_out = tag6_reg;
    assign press   = press_reg;

endmodule

### design/bcc_checker.sv
// ----------------------------------------------------------------------------
// Barometer compensation checker
// Port-level checks of the compensation core, bound to the top level.
// ----------------------------------------------------------------------------
`include "barometer_compensation_core_macros.svh"

module bcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    // No result word may be shown right after reset.
    `BCC_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // A stalled result word holds its contents.
    `BCC_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // A zero divisor forces the pressure to zero.
    `BCC_ASSERT(a_invalid_zero, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata[47:16] == 32'd0, "invalid pressure not zero")

    // The input side stalls exactly when a result is waiting and not taken.
    `BCC_ASSERT(a_ready_follows, aclk, aresetn, s_tready == (!m_tvalid || m_tready), "input ready does not follow output")

endmodule

bind barometer_compensation_core bcc_checker u_bcc_checker (.*);
